@@ rtl/pcp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcp_pkg
// Shared types, constants and the character classifier of the patch code
// parser.
// ----------------------------------------------------------------------------
package pcp_pkg;

  localparam int STORE_DEPTH = 11;
  localparam int POS_W       = 4;

  localparam logic [POS_W-1:0] POS_SAT     = 4'd12;
  localparam logic [POS_W-1:0] LEN_PLAIN   = 4'd7;
  localparam logic [POS_W-1:0] LEN_COLON   = 4'd8;
  localparam logic [POS_W-1:0] LEN_COMPARE = 4'd11;
  localparam logic [POS_W-1:0] SEP_POS     = 4'd5;
  localparam logic [POS_W-1:0] CMP_SEP_POS = 4'd8;

  localparam logic [7:0] CHAR_COLON = 8'h3A;  // ':'
  localparam logic [7:0] CHAR_QUERY = 8'h3F;  // '?'
  localparam logic [3:0] HEX_ALPHA  = 4'd10;

  localparam logic [19:0] LIMIT_RESET = 20'h1FFFF;

  localparam int MID_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF = 2;

  // Classified code, handed from front to back
  typedef struct packed {
    logic [POS_W-1:0]                 len;
    logic [STORE_DEPTH-1:0][3:0]      nib;
    logic [STORE_DEPTH-1:0]           is_hex;
    logic                             colon5;
    logic                             query5;
    logic                             colon8;
  } code_rec_t;

  typedef struct packed {
    logic        code_valid;
    logic [19:0] patch_address;
    logic [7:0]  patch_value;
    logic [7:0]  compare_byte;
    logic        has_compare;
  } result_t;

  localparam int REC_W = $bits(code_rec_t);
  localparam int RES_W = $bits(result_t);

  // {is_hex, nibble}
  function automatic logic [4:0] hex_class(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h61) + HEX_ALPHA};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h41) + HEX_ALPHA};
    end
    return r;
  endfunction

endpackage

@@ rtl/pcp_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcp_fifo
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module pcp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ rtl/pcp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcp_front
// Takes characters, classifies and stores them, and emits one code record
// on the last character.
// ----------------------------------------------------------------------------
module pcp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          char_code,
  input  logic                last_char,
  output logic                rec_push,
  output pcp_pkg::code_rec_t  rec
);

  import pcp_pkg::*;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_inc;
  logic [3:0]       nib_q [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] hex_q;
  logic             colon5;
  logic             query5;
  logic             colon8;
  logic [4:0]       cls;
  logic             in_store;

  assign cls      = hex_class(char_code);
  assign in_store = (pos < POS_W'(STORE_DEPTH));
  assign pos_inc  = (pos == POS_SAT) ? POS_SAT : pos + 1'b1;
  assign rec_push = accept && last_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= last_char ? '0 : pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_store) begin
      nib_q[pos] <= cls[3:0];
      hex_q[pos] <= cls[4];
    end
    if (accept && (pos == SEP_POS)) begin
      colon5 <= (char_code == CHAR_COLON);
      query5 <= (char_code == CHAR_QUERY);
    end
    if (accept && (pos == CMP_SEP_POS)) begin
      colon8 <= (char_code == CHAR_COLON);
    end
  end

  // Record = stored characters with the current one merged in
  always_comb begin
    rec.len = pos_inc;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      rec.nib[i]    = nib_q[i];
      rec.is_hex[i] = hex_q[i];
    end
    if (in_store) begin
      rec.nib[pos]    = cls[3:0];
      rec.is_hex[pos] = cls[4];
    end
    rec.colon5 = (pos == SEP_POS) ? (char_code == CHAR_COLON) : colon5;
    rec.query5 = (pos == SEP_POS) ? (char_code == CHAR_QUERY) : query5;
    rec.colon8 = (pos == CMP_SEP_POS) ? (char_code == CHAR_COLON) : colon8;
  end

endmodule

@@ rtl/pcp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcp_back
// Decodes one code record into a patch result and checks the address limit.
// ----------------------------------------------------------------------------
module pcp_back (
  input  logic                rec_ready,
  input  pcp_pkg::code_rec_t  rec,
  input  logic [19:0]         address_limit,
  input  logic                out_full,
  output logic                rec_pop,
  output logic                res_push,
  output pcp_pkg::result_t    res
);

  import pcp_pkg::*;

  logic        lay_plain;
  logic        lay_colon;
  logic        lay_cmp;
  logic        addr_hex;
  logic        ok;
  logic [19:0] addr;
  logic [7:0]  val;
  logic [7:0]  cmp;

  assign rec_pop  = rec_ready && !out_full;
  assign res_push = rec_pop;

  assign addr     = {rec.nib[0], rec.nib[1], rec.nib[2], rec.nib[3], rec.nib[4]};
  assign addr_hex = &rec.is_hex[4:0];

  always_comb begin
    lay_colon = (rec.len == LEN_COLON) && rec.colon5
                && rec.is_hex[6] && rec.is_hex[7];
    lay_plain = (rec.len == LEN_PLAIN) && rec.is_hex[5] && rec.is_hex[6];
    lay_cmp   = (rec.len == LEN_COMPARE) && rec.query5 && rec.colon8
                && rec.is_hex[6] && rec.is_hex[7]
                && rec.is_hex[9] && rec.is_hex[10];

    if (lay_plain) begin
      val = {rec.nib[5], rec.nib[6]};
    end else if (lay_colon) begin
      val = {rec.nib[6], rec.nib[7]};
    end else begin
      val = {rec.nib[9], rec.nib[10]};
    end
    cmp = {rec.nib[6], rec.nib[7]};

    ok = addr_hex && (lay_plain || lay_colon || lay_cmp) && (addr <= address_limit);

    res.code_valid    = ok;
    res.patch_address = ok ? addr : '0;
    res.patch_value   = ok ? val : '0;
    res.compare_byte  = (ok && lay_cmp) ? cmp : '0;
    res.has_compare   = ok && lay_cmp;
  end

endmodule

@@ rtl/patch_code_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// patch_code_parser
// Parses memory-patch codes one character per item into patch results.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  input    | push / full        | char_code, last_char
//  result   | pop / empty        | code_valid, patch_address, patch_value,
//           |                    | compare_byte, has_compare
//  config   | cfg_write          | cfg_data (address_limit)
//
//  One character item is taken every cycle while full is low. A code's record
//  is written into the record queue on the edge that takes its last
//  character; the decoder moves it into the result queue once it heads the
//  record queue and the result queue has room.
//  Synchronous reset empties both queues and restarts the character count;
//  address_limit returns to 0x1FFFF.
//  full rises only when the record queue is full; the front then holds off
//  every character. A stalled result side fills the result queue, then the
//  record queue.
// ----------------------------------------------------------------------------
module patch_code_parser #(
  parameter int MID_DEPTH = pcp_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH = pcp_pkg::OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // character items
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  // result items
  input  logic        pop,
  output logic        empty,
  output logic        code_valid,
  output logic [19:0] patch_address,
  output logic [7:0]  patch_value,
  output logic [7:0]  compare_byte,
  output logic        has_compare,
  // configuration
  input  logic        cfg_write,
  input  logic [19:0] cfg_data
);

  import pcp_pkg::*;

  logic        accept;
  logic [19:0] address_limit;

  code_rec_t   front_rec;
  code_rec_t   mid_rec;
  logic        rec_push;
  logic        mid_full;
  logic        mid_empty;
  logic        rec_pop;

  result_t     back_res;
  result_t     out_res;
  logic        res_push;
  logic        out_full;

  // Any character is held off while the record queue is full: the front
  // has no room to finish a code.
  assign full   = mid_full;
  assign accept = push && !full;

  // Limit register, written directly
  always_ff @(posedge clk) begin
    if (rst) begin
      address_limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      address_limit <= cfg_data;
    end
  end

  pcp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (char_code),
    .last_char (last_char),
    .rec_push  (rec_push),
    .rec       (front_rec)
  );

  // Record queue between front and back
  pcp_fifo #(
    .WIDTH (REC_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .push    (rec_push),
    .wr_data (front_rec),
    .full    (mid_full),
    .pop     (rec_pop),
    .rd_data (mid_rec),
    .empty   (mid_empty)
  );

  pcp_back u_back (
    .rec_ready     (!mid_empty),
    .rec           (mid_rec),
    .address_limit (address_limit),
    .out_full      (out_full),
    .rec_pop       (rec_pop),
    .res_push      (res_push),
    .res           (back_res)
  );

  // Result queue: parts the decoder from the consumer
  pcp_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (back_res),
    .full    (out_full),
    .pop     (pop),
    .rd_data (out_res),
    .empty   (empty)
  );

  assign code_valid    = out_res.code_valid;
  assign patch_address = out_res.patch_address;
  assign patch_value   = out_res.patch_value;
  assign compare_byte  = out_res.compare_byte;
  assign has_compare   = out_res.has_compare;

  // Assertions
  a_reset_empty : assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (empty && !full))
    else $error("queues not empty after reset");

  a_invalid_zero : assert property (@(posedge clk) disable iff (rst)
    (!empty && !code_valid) |-> (patch_address == '0 && patch_value == '0
                                 && compare_byte == '0 && !has_compare))
    else $error("invalid result carries non-zero fields");

  a_cmp_valid : assert property (@(posedge clk) disable iff (rst)
    (!empty && has_compare) |-> code_valid)
    else $error("compare flag on an invalid result");

  a_no_result_mid_code : assert property (@(posedge clk) disable iff (rst)
    (accept && !last_char) |-> !rec_push)
    else $error("record pushed before the last character");

endmodule
